// File: rtl/core/vsa_pkg.sv
// Shared types and constants for the voice slot allocator.
`default_nettype none
package vsa_pkg;
   localparam logic [31:0] OWNER_NONE = 32'hFFFF_FFFF;

   localparam logic [3:0] KIND_ALLOC       = 4'd0;
   localparam logic [3:0] KIND_ALLOC_AT    = 4'd1;
   localparam logic [3:0] KIND_ALLOC_OWNER = 4'd2;
   localparam logic [3:0] KIND_FREE        = 4'd3;
   localparam logic [3:0] KIND_FREE_OWNER  = 4'd4;
   localparam logic [3:0] KIND_FIND_OWNER  = 4'd5;
   localparam logic [3:0] KIND_SET_LOOP    = 4'd6;
   localparam logic [3:0] KIND_SET_OWNER   = 4'd7;
   localparam logic [3:0] KIND_TOUCH       = 4'd8;

   localparam logic CSR_IDX_VOICE_COUNT = 1'b0;

   typedef struct packed {
      logic        in_use;
      logic        looping;
      logic [31:0] stamp;
      logic [31:0] owner;
   } entry_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [5:0]  slot;
      logic [1:0]  force_mode;
      logic [31:0] owner_id;
      logic        loop_flag;
      logic [31:0] now;
   } cmd_type;

   typedef struct packed {
      logic       status;
      logic [5:0] slot_out;
      logic       stolen;
      logic [5:0] stolen_slot;
   } result_type;
endpackage
`default_nettype wire

// File: rtl/core/voice_slot_allocator_unit.sv
// Voice slot allocator: rotating ring of slot cells, sequencer, stream and APB ports.
//
// The slot table is a ring of MAX_VOICES cells that rotates one slot per
// cycle, while a command is scanned or applied, past a single sequencer at
// its head. Each accepted command runs in steps: one full revolution gathers
// the lowest free slot, the oldest stealable slot and the owner matches, a
// second revolution writes the changes as each slot passes the head, and a
// wait state hands the result to the output register once the output is free.
// A new command is taken while the previous result still waits on the result
// channel. The table is cleared by reset.
`default_nettype none
module voice_slot_allocator_unit
   import vsa_pkg::*;
#(
   parameter int MAX_VOICES = 64
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata, low bit up: slot[5:0], force_mode[7:6], owner_id[39:8],
   // loop_flag[40], now[72:41], zero fill [79:73]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,
   // req_tuser: kind[3:0]
   input  wire logic [3:0]  req_tuser,
   // rsp_tdata, low bit up: slot_out[5:0], stolen[6], stolen_slot[12:7],
   // zero fill [15:13]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   // rsp_tuser: status[0]
   output logic             rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [6:0]  voice_count_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   cmd_type     cmd;
   entry_type   ring [MAX_VOICES];
   entry_type   tail;
   result_type  result;
   logic        idle, shift, done, start, out_free;

   assign cmd.kind       = req_tuser;
   assign cmd.slot       = req_tdata[5:0];
   assign cmd.force_mode = req_tdata[7:6];
   assign cmd.owner_id   = req_tdata[39:8];
   assign cmd.loop_flag  = req_tdata[40];
   assign cmd.now        = req_tdata[72:41];

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_VOICES; gi++) begin : g_cell
         vsa_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d     ((gi == MAX_VOICES - 1) ? tail : ring[(gi + 1) % MAX_VOICES]),
            .q     (ring[gi])
         );
      end
   endgenerate

   vsa_ctrl #(.MAX_VOICES(MAX_VOICES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (cmd),
      .voice_count (voice_count_ff),
      .head        (ring[0]),
      .out_free    (out_free),
      .idle        (idle),
      .shift       (shift),
      .tail        (tail),
      .done        (done),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         voice_count_ff <= 7'd64;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite &&
             csr_paddr[2] == CSR_IDX_VOICE_COUNT) begin
            voice_count_ff <= csr_pwdata[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'd0, rsp_ff.stolen_slot, rsp_ff.stolen, rsp_ff.slot_out};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_VOICE_COUNT) ?
                       {25'd0, voice_count_ff} : 32'd0;
endmodule
`default_nettype wire

// File: rtl/core/vsa_cell.sv
// One voice slot cell of the rotating slot ring.
`default_nettype none
module vsa_cell
   import vsa_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      shift,
   input  wire entry_type d,
   output entry_type      q
);
   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= d;
      end
   end

   assign q = entry_ff;
endmodule
`default_nettype wire

// File: rtl/core/vsa_ctrl.sv
// Command sequencer: scans the ring head in one revolution, applies in the next.
`default_nettype none
module vsa_ctrl
   import vsa_pkg::*;
#(
   parameter int MAX_VOICES = 64
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire cmd_type   cmd,
   input  wire logic [6:0] voice_count,
   input  wire entry_type head,
   input  wire logic      out_free,
   output logic           idle,
   output logic           shift,
   output entry_type      tail,
   output logic           done,
   output result_type     result
);
   localparam int IW    = $clog2(MAX_VOICES);
   localparam int CW    = $clog2(MAX_VOICES + 1);
   localparam int CMP_W = (CW > 7) ? CW : 7;
   localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_VOICES);
   localparam logic [IW-1:0] LAST_POS = IW'(MAX_VOICES - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] pos_ff, pos_in;
   cmd_type       cmd_ff;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic          steal_found_ff, steal_found_in;
   logic [IW-1:0] steal_idx_ff, steal_idx_in;
   logic [31:0]   steal_time_ff, steal_time_in;
   logic          match_found_ff, match_found_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic          find_found_ff, find_found_in;
   logic [IW-1:0] find_idx_ff, find_idx_in;
   logic          tgt_used_ff, tgt_used_in;

   logic [CMP_W-1:0] n_c, idx_c, slot_c;
   logic             in_range, slot_ok, at_slot, owner_hit, loop_ok, last;
   logic             ok;
   logic             stole;
   logic [IW-1:0]    tgt;

   assign n_c    = (CMP_W'(voice_count) > MAX_C) ? MAX_C : CMP_W'(voice_count);
   assign idx_c  = CMP_W'(pos_ff);
   assign slot_c = CMP_W'(cmd_ff.slot);
   assign in_range  = idx_c < n_c;
   assign slot_ok   = slot_c < n_c;
   assign at_slot   = idx_c == slot_c;
   assign owner_hit = in_range && head.in_use && (head.owner == cmd_ff.owner_id);
   assign loop_ok   = (cmd_ff.force_mode[0] && !head.looping) ||
                      (cmd_ff.force_mode[1] && head.looping);
   assign last      = pos_ff == LAST_POS;

   // Outcome of the command, from what the scan revolution collected.
   always_comb begin
      ok    = 1'b0;
      stole = 1'b0;
      tgt   = IW'(cmd_ff.slot);
      case (cmd_ff.kind)
         KIND_ALLOC, KIND_ALLOC_OWNER: begin
            if (free_found_ff) begin
               ok  = 1'b1;
               tgt = free_idx_ff;
            end else if (cmd_ff.force_mode != 2'd0 && steal_found_ff) begin
               ok    = 1'b1;
               stole = 1'b1;
               tgt   = steal_idx_ff;
            end
         end
         KIND_ALLOC_AT: begin
            ok    = slot_ok && (!tgt_used_ff || cmd_ff.force_mode != 2'd0);
            stole = ok && tgt_used_ff;
         end
         KIND_FREE: ok = slot_ok;
         KIND_FREE_OWNER: begin
            ok  = match_found_ff;
            tgt = match_idx_ff;
         end
         KIND_FIND_OWNER: begin
            ok  = slot_ok && find_found_ff;
            tgt = find_idx_ff;
         end
         KIND_SET_LOOP, KIND_SET_OWNER, KIND_TOUCH: ok = slot_ok && tgt_used_ff;
         default: ok = 1'b0;
      endcase
   end

   // Head entry as it re-enters the ring at the tail.
   always_comb begin
      tail = head;
      if (state_ff == ST_APPLY && ok) begin
         if (pos_ff == tgt) begin
            case (cmd_ff.kind)
               KIND_ALLOC, KIND_ALLOC_AT, KIND_ALLOC_OWNER: begin
                  tail.in_use  = 1'b1;
                  tail.looping = 1'b0;
                  tail.stamp   = cmd_ff.now;
                  tail.owner   = (cmd_ff.kind == KIND_ALLOC_OWNER) ?
                                 cmd_ff.owner_id : OWNER_NONE;
               end
               KIND_FREE:      tail.in_use  = 1'b0;
               KIND_SET_LOOP:  tail.looping = cmd_ff.loop_flag;
               KIND_SET_OWNER: tail.owner   = cmd_ff.owner_id;
               KIND_TOUCH:     tail.stamp   = cmd_ff.now;
               default:        tail = head;
            endcase
         end
         if (cmd_ff.kind == KIND_FREE_OWNER && owner_hit) begin
            tail.in_use = 1'b0;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      steal_found_in = steal_found_ff;
      steal_idx_in   = steal_idx_ff;
      steal_time_in  = steal_time_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      find_found_in  = find_found_ff;
      find_idx_in    = find_idx_ff;
      tgt_used_in    = tgt_used_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in       = ST_SCAN;
               pos_in         = '0;
               free_found_in  = 1'b0;
               steal_found_in = 1'b0;
               match_found_in = 1'b0;
               find_found_in  = 1'b0;
               tgt_used_in    = 1'b0;
            end
         end
         ST_SCAN: begin
            if (in_range && !head.in_use && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = pos_ff;
            end
            if (in_range && head.in_use && loop_ok &&
                (!steal_found_ff || head.stamp < steal_time_ff)) begin
               steal_found_in = 1'b1;
               steal_idx_in   = pos_ff;
               steal_time_in  = head.stamp;
            end
            if (owner_hit && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = pos_ff;
            end
            if (owner_hit && idx_c >= slot_c && !find_found_ff) begin
               find_found_in = 1'b1;
               find_idx_in   = pos_ff;
            end
            if (at_slot) begin
               tgt_used_in = head.in_use;
            end
            pos_in = last ? '0 : pos_ff + 1'b1;
            if (last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            pos_in = last ? '0 : pos_ff + 1'b1;
            if (last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         cmd_ff <= cmd;
      end
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      steal_found_ff <= steal_found_in;
      steal_idx_ff   <= steal_idx_in;
      steal_time_ff  <= steal_time_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      find_found_ff  <= find_found_in;
      find_idx_ff    <= find_idx_in;
      tgt_used_ff    <= tgt_used_in;
   end

   assign idle  = state_ff == ST_IDLE;
   assign shift = state_ff == ST_SCAN || state_ff == ST_APPLY;
   assign done  = state_ff == ST_WAIT && out_free;

   assign result.status      = !ok;
   assign result.slot_out    = ok ? 6'(tgt) : 6'd0;
   assign result.stolen      = stole;
   assign result.stolen_slot = stole ? 6'(tgt) : 6'd0;
endmodule
`default_nettype wire
